@@ design/mbf_pkg.sv @@
// Package: shared constants, command codes and sequencer states for the biquad filterbank.
package mbf_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int BANDS_DEF       = 8;
  localparam int SECTIONS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int WORD_BITS = 32;
  localparam int FRAC      = 28;
  localparam int PROD_BITS = 64;
  localparam int ACC_BITS  = 67;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_COEF   = 2'd1;
  localparam logic [1:0] CMD_DELAY  = 2'd2;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;
  localparam logic [2:0] SLOT_W1 = 3'd0;
  localparam logic [2:0] SLOT_W2 = 3'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_RD_WAIT,
    ST_MA1,
    ST_MA2,
    ST_MA3,
    ST_W0,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_MB3,
    ST_Y,
    ST_DONE
  } state_t;

endpackage

@@ design/multichannel_biquad_filterbank_top.sv @@
// A sample is filtered by the n sections in use in turn, all sharing the one 32x32 MAC
// (5 products per section), and the result is then presented with out_valid.
// Writes of coefficients or delay words are done directly in idle. One item is worked on at a time.
// Reset: a clearing pass over all 64 cascade sections (one per cycle) zeroes the coefficient
// and delay memories; no item is accepted during it. sections_in_use resets to 4.
module multichannel_biquad_filterbank_top #(
  parameter int CHANNELS    = mbf_pkg::CHANNELS_DEF,
  parameter int BANDS       = mbf_pkg::BANDS_DEF,
  parameter int SECTIONS    = mbf_pkg::SECTIONS_DEF,
  parameter int SAMPLE_BITS = mbf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_sections_in_use,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic                          in_channel,
  input  logic [2:0]                    in_band,
  input  logic [1:0]                    in_section,
  input  logic [2:0]                    in_slot,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic signed [31:0]            in_word_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_channel,
  output logic [2:0]                    out_band,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_saturated
);
  import mbf_pkg::*;

  localparam int CASC  = CHANNELS * BANDS * SECTIONS;
  localparam int AW    = (CASC > 1) ? $clog2(CASC) : 1;
  localparam int SW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CBW   = (CHANNELS * BANDS > 1) ? $clog2(CHANNELS * BANDS) : 1;
  localparam int CNTW  = $clog2(SECTIONS + 1);
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // memories: five coefficients and two delay words per cascade section
  logic [5*WORD_BITS-1:0] coef_mem [CASC];
  logic [WORD_BITS-1:0]   dly1_mem [CASC];
  logic [WORD_BITS-1:0]   dly2_mem [CASC];
  logic [5*WORD_BITS-1:0] coef_q;
  logic [WORD_BITS-1:0]   dly1_q, dly2_q;

  state_t state_r, state_nxt;
  logic [2:0]              siu_r;
  logic [AW-1:0]           clr_addr_r;
  logic [CBW-1:0]          casc_r;
  logic [SW-1:0]           sec_r;
  logic [CNTW-1:0]         nsec_r;
  logic                    chan_r;
  logic [2:0]              band_r;
  logic signed [WORD_BITS-1:0] x_r, w0_r, w1_r, w2_r;
  logic [5*WORD_BITS-1:0]  c_r;
  logic signed [ACC_BITS-1:0]  acc_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic                    sat_r;
  logic                    ov_r;
  logic                    ov_ch_r;
  logic [2:0]              ov_band_r;
  logic signed [SAMPLE_BITS-1:0] ov_smp_r;
  logic                    ov_sat_r;

  logic accept, out_take, in_range, take_sample;
  logic [AW-1:0] rd_addr, wr_addr_item, sec_addr;
  logic [CNTW-1:0] n_eff;

  assign accept   = in_valid && !in_stall;
  assign out_take = ov_r && !out_stall;
  assign in_range = (32'(in_channel) < CHANNELS) && (32'(in_band) < BANDS);
  assign take_sample = accept && in_range && in_cmd == CMD_SAMPLE;
  assign n_eff = (32'(siu_r) > SECTIONS) ? CNTW'(SECTIONS) : CNTW'(siu_r);

  function automatic logic [AW-1:0] addr_of(input logic [CBW-1:0] cb, input logic [SW-1:0] s);
    logic [31:0] a;
    a = 32'(cb) * SECTIONS + 32'(s);
    return a[AW-1:0];
  endfunction

  logic [CBW-1:0] in_cb;
  logic [31:0] in_cb_full;
  assign in_cb_full = 32'(in_channel) * BANDS + 32'(in_band);
  assign in_cb = in_cb_full[CBW-1:0];
  assign wr_addr_item = addr_of(in_cb, in_section[SW-1:0]);
  assign sec_addr = addr_of(casc_r, sec_r);
  assign rd_addr = sec_addr;

  // in_stall: accept only in idle with the output register free
  assign in_stall = !(state_r == ST_IDLE && !ov_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (take_sample) state_nxt = (n_eff == '0) ? ST_DONE : ST_RD;
      ST_CLEAR:   if (32'(clr_addr_r) == CASC - 1) state_nxt = ST_IDLE;
      ST_RD:      state_nxt = ST_RD_WAIT;
      ST_RD_WAIT: state_nxt = ST_MA1;
      ST_MA1:     state_nxt = ST_MA2;
      ST_MA2:     state_nxt = ST_MA3;
      ST_MA3:     state_nxt = ST_W0;
      ST_W0:      state_nxt = ST_MB0;
      ST_MB0:     state_nxt = ST_MB1;
      ST_MB1:     state_nxt = ST_MB2;
      ST_MB2:     state_nxt = ST_MB3;
      ST_MB3:     state_nxt = ST_Y;
      ST_Y:       state_nxt = (32'(sec_r) + 1 >= 32'(nsec_r)) ? ST_DONE : ST_RD;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // operand selection for the shared multiplier
  logic signed [WORD_BITS-1:0] op_a, op_b;
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      ST_MA1: begin op_a = c_r[SLOT_A1*WORD_BITS +: WORD_BITS]; op_b = w1_r; end
      ST_MA2: begin op_a = c_r[SLOT_A2*WORD_BITS +: WORD_BITS]; op_b = w2_r; end
      ST_MB0: begin op_a = c_r[SLOT_B0*WORD_BITS +: WORD_BITS]; op_b = w0_r; end
      ST_MB1: begin op_a = c_r[SLOT_B1*WORD_BITS +: WORD_BITS]; op_b = w1_r; end
      ST_MB2: begin op_a = c_r[SLOT_B2*WORD_BITS +: WORD_BITS]; op_b = w2_r; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // round to nearest (ties up) and saturate to a word
  logic signed [ACC_BITS-1:0] rnd_full;
  logic signed [ACC_BITS-FRAC-1:0] rnd_q;
  logic rnd_hi, rnd_lo;
  logic signed [WORD_BITS-1:0] rnd_word;
  assign rnd_full = acc_r + ACC_BITS'(signed'(65'sd1 <<< (FRAC - 1)));
  assign rnd_q    = rnd_full[ACC_BITS-1:FRAC];
  assign rnd_hi   = rnd_q > ACC_BITS'(WMAX);
  assign rnd_lo   = rnd_q < ACC_BITS'(WMIN);
  assign rnd_word = rnd_hi ? WMAX : (rnd_lo ? WMIN : rnd_q[WORD_BITS-1:0]);

  localparam logic signed [WORD_BITS-1:0] SMAX = WORD_BITS'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [WORD_BITS-1:0] SMIN = -SMAX - 1;
  logic signed [WORD_BITS-1:0] y_fin;
  logic y_clip;
  assign y_clip = (x_r > SMAX) || (x_r < SMIN);
  assign y_fin  = (x_r > SMAX) ? SMAX : ((x_r < SMIN) ? SMIN : x_r);

  // memory ports: clearing, item writes and write-back share one write per memory
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      coef_mem[clr_addr_r] <= '0;
      dly1_mem[clr_addr_r] <= '0;
      dly2_mem[clr_addr_r] <= '0;
    end else if (state_r == ST_IDLE && accept && in_range &&
                 32'(in_section) < SECTIONS) begin
      if (in_cmd == CMD_COEF && in_slot <= SLOT_A2)
        coef_mem[wr_addr_item][in_slot*WORD_BITS +: WORD_BITS] <= in_word_value;
      if (in_cmd == CMD_DELAY && in_slot == SLOT_W1) dly1_mem[wr_addr_item] <= in_word_value;
      if (in_cmd == CMD_DELAY && in_slot == SLOT_W2) dly2_mem[wr_addr_item] <= in_word_value;
    end else if (state_r == ST_W0) begin
      dly1_mem[sec_addr] <= rnd_word;
      dly2_mem[sec_addr] <= w1_r;
    end
    coef_q <= coef_mem[rd_addr];
    dly1_q <= dly1_mem[rd_addr];
    dly2_q <= dly2_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      siu_r      <= 3'd4;
      ov_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (cfg_we) siu_r <= cfg_sections_in_use;
      if (state_r == ST_DONE) ov_r <= 1'b1;
      else if (out_take) ov_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    unique case (state_r)
      ST_IDLE: if (take_sample) begin
        casc_r <= in_cb;
        sec_r  <= '0;
        nsec_r <= n_eff;
        chan_r <= in_channel;
        band_r <= in_band;
        x_r    <= WORD_BITS'(in_sample_in);
        sat_r  <= 1'b0;
      end
      ST_RD_WAIT: begin
        c_r  <= coef_q;
        w1_r <= dly1_q;
        w2_r <= dly2_q;
        acc_r <= ACC_BITS'(x_r) <<< FRAC;
      end
      ST_MA2, ST_MA3: acc_r <= acc_r - ACC_BITS'(prod_r);
      ST_W0: begin
        w0_r  <= rnd_word;
        sat_r <= sat_r | rnd_hi | rnd_lo;
        acc_r <= '0;
      end
      ST_MB1, ST_MB2, ST_MB3: acc_r <= acc_r + ACC_BITS'(prod_r);
      ST_Y: begin
        x_r   <= rnd_word;
        sat_r <= sat_r | rnd_hi | rnd_lo;
        sec_r <= sec_r + 1'b1;
      end
      ST_DONE: begin
        ov_ch_r   <= chan_r;
        ov_band_r <= band_r;
        ov_smp_r  <= y_fin[SAMPLE_BITS-1:0];
        ov_sat_r  <= sat_r | y_clip;
      end
      default: ;
    endcase
  end

  assign out_valid      = ov_r;
  assign out_channel    = ov_ch_r;
  assign out_band       = ov_band_r;
  assign out_sample_out = ov_smp_r;
  assign out_saturated  = ov_sat_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall)
    else $error("request taken while busy");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> !ov_r)
    else $error("result register overwritten");
endmodule
